@@ src/hfdp_pkg.sv @@
// ----------------------------------------------------------------------------
// hfdp_pkg: shared types and constants for the header framed decimal pair parser
// Byte codes of the frame header, the abort byte, payload sizing and the
// three-digit code function used by the parser.
// ----------------------------------------------------------------------------
package hfdp_pkg;

	localparam int ByteW = 8;
	localparam int CodeW = 16;

	// frame header letters and the abort byte
	localparam logic [ByteW-1:0] HdrB0     = 8'h48;
	localparam logic [ByteW-1:0] HdrB1     = 8'h45;
	localparam logic [ByteW-1:0] HdrB2     = 8'h41;
	localparam logic [ByteW-1:0] HdrB3     = 8'h44;
	localparam logic [ByteW-1:0] AbortByte = 8'h0D;

	// ascii digit offset
	localparam logic signed [CodeW-1:0] DigitBase = 16'sd48;

	// payload sizing: the last byte is used directly and never stored
	localparam int PayloadLen = 7;
	localparam int StoreDepth = PayloadLen - 1;
	localparam int CountW     = $clog2(PayloadLen);
	localparam logic [CountW-1:0] LastIdx = CountW'(PayloadLen - 1);

	// one registered request from the input stage
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
	} hfdp_item_t;

	// d0*100 + d1*10 + d2, each digit the byte minus the ascii base
	function automatic logic signed [CodeW-1:0] three_digit_code(
		input logic [ByteW-1:0] b0,
		input logic [ByteW-1:0] b1,
		input logic [ByteW-1:0] b2
	);
		logic signed [CodeW-1:0] d0;
		logic signed [CodeW-1:0] d1;
		logic signed [CodeW-1:0] d2;
		d0 = signed'({{(CodeW-ByteW){1'b0}}, b0}) - DigitBase;
		d1 = signed'({{(CodeW-ByteW){1'b0}}, b1}) - DigitBase;
		d2 = signed'({{(CodeW-ByteW){1'b0}}, b2}) - DigitBase;
		return d0 * 16'sd100 + d1 * 16'sd10 + d2;
	endfunction

endpackage

@@ src/header_framed_decimal_pair_parser_top.sv @@
// ----------------------------------------------------------------------------
// header_framed_decimal_pair_parser_top: framed decimal pair parser
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   input   | in_valid / in_stall  | rx_byte [7:0]
//   output  | out_valid / out_stall| lead_code [15:0], trail_code [15:0]
//
// One byte is taken per cycle while in_stall is low. A byte goes through
// the input register and the parser; the closing byte loads the result.
// The parser holds an input only when a frame closes while the previous
// result is still stalled in the result register. Reset returns the header
// state machine to idle and empties both registers.
// ----------------------------------------------------------------------------
module header_framed_decimal_pair_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [hfdp_pkg::ByteW-1:0]        rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [hfdp_pkg::CodeW-1:0] lead_code,
	output logic signed [hfdp_pkg::CodeW-1:0] trail_code
);

	hfdp_pkg::hfdp_item_t item;
	logic                 consume;

	// input register
	hfdp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.consume  (consume),
		.item     (item)
	);

	// header match, capture and result register
	hfdp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.consume    (consume),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lead_code  (lead_code),
		.trail_code (trail_code)
	);

endmodule

@@ src/hfdp_in_stage.sv @@
// ----------------------------------------------------------------------------
// hfdp_in_stage: input register
// Captures one received byte per request and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module hfdp_in_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [hfdp_pkg::ByteW-1:0] rx_byte,
	input  logic                     consume,
	output hfdp_pkg::hfdp_item_t     item
);

	logic                       valid_s1;
	logic [hfdp_pkg::ByteW-1:0] rx_byte_s1;

	// hold while a byte sits here that the parser cannot take
	assign in_stall = valid_s1 && !consume;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = rx_byte_s1;

endmodule

@@ src/hfdp_parser.sv @@
// ----------------------------------------------------------------------------
// hfdp_parser: header match, payload capture and code result register
// Walks the header state machine one byte at a time, stores payload bytes
// and on the last payload byte registers the two three-digit codes.
// ----------------------------------------------------------------------------
module hfdp_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hfdp_pkg::hfdp_item_t            item,
	output logic                            consume,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [hfdp_pkg::CodeW-1:0] lead_code,
	output logic signed [hfdp_pkg::CodeW-1:0] trail_code
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_DATA
	} state_t;

	state_t                        state_q;
	logic [hfdp_pkg::CountW-1:0]   payload_count_q;
	logic [hfdp_pkg::ByteW-1:0]    payload_q [hfdp_pkg::StoreDepth];
	logic                          out_valid_q;
	logic signed [hfdp_pkg::CodeW-1:0] lead_code_q;
	logic signed [hfdp_pkg::CodeW-1:0] trail_code_q;

	logic is_data;
	logic emit;
	logic store;
	logic signed [hfdp_pkg::CodeW-1:0] first_next;
	logic signed [hfdp_pkg::CodeW-1:0] second_next;

	// a non-abort byte in the payload phase, and whether it closes the frame
	assign is_data = item.valid && (state_q == ST_DATA) && (item.data != hfdp_pkg::AbortByte);
	assign emit    = is_data && (payload_count_q == hfdp_pkg::LastIdx);
	assign store   = is_data && !emit && consume;

	// only a closing byte waits, and only on a full, stalled result register
	assign consume = !(emit && out_valid_q && out_stall);

	// codes from the stored bytes; the last digit is the current byte
	assign first_next  = hfdp_pkg::three_digit_code(payload_q[0], payload_q[1], payload_q[2]);
	assign second_next = hfdp_pkg::three_digit_code(payload_q[4], payload_q[5], item.data);

	// state machine and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			payload_count_q <= '0;
			out_valid_q     <= 1'b0;
			lead_code_q     <= '0;
			trail_code_q    <= '0;
		end else begin
			if (emit && consume) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (item.valid && consume) begin
				unique case (state_q)
					ST_IDLE: begin
						state_q <= (item.data == hfdp_pkg::HdrB0) ? ST_H1 : ST_IDLE;
					end
					ST_H1: begin
						state_q <= (item.data == hfdp_pkg::HdrB1) ? ST_H2 : ST_IDLE;
					end
					ST_H2: begin
						state_q <= (item.data == hfdp_pkg::HdrB2) ? ST_H3 : ST_IDLE;
					end
					ST_H3: begin
						if (item.data == hfdp_pkg::HdrB3) begin
							state_q         <= ST_DATA;
							payload_count_q <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_DATA: begin
						if (!is_data) begin
							state_q <= ST_IDLE;
						end else if (emit) begin
							state_q         <= ST_IDLE;
							payload_count_q <= '0;
							lead_code_q     <= first_next;
							trail_code_q    <= second_next;
						end else begin
							payload_count_q <= payload_count_q + 1'b1;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// payload byte store
	always_ff @(posedge clk) begin
		if (store) begin
			payload_q[payload_count_q] <= item.data;
		end
	end

	assign out_valid  = out_valid_q;
	assign lead_code  = lead_code_q;
	assign trail_code = trail_code_q;

endmodule

@@ tb/tb_header_framed_decimal_pair_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_header_framed_decimal_pair_parser_top: self-checking bench for the parser
// Feeds serial bytes through the valid/stall input channel: a short table of
// header, abort and extreme-value frames, then random frames, broken headers
// and noise. The table gives the extreme pair; a local model of the header
// matcher and payload capture predicts the rest. Each output pair is compared
// with the oldest prediction. Channels idle at random in two of three phases.
// ----------------------------------------------------------------------------
module tb_header_framed_decimal_pair_parser_top;

	// header matcher states of the local model
	typedef enum logic [2:0] {
		StageIdle,
		StageGotH,
		StageGotE,
		StageGotA,
		StagePayload
	} frame_stage_t;

	localparam int AsciiZero    = 48;
	localparam int PayloadBytes = 7;
	localparam int SepIdx       = 3;
	localparam int TailCycles   = 20;
	localparam int PhaseBytes   = 420;

	localparam logic [hfdp_pkg::ByteW-1:0] HeaderSeq [4] = '{
		hfdp_pkg::HdrB0, hfdp_pkg::HdrB1, hfdp_pkg::HdrB2, hfdp_pkg::HdrB3
	};

	typedef struct packed {
		logic signed [hfdp_pkg::CodeW-1:0] first;
		logic signed [hfdp_pkg::CodeW-1:0] second;
	} code_pair_t;

	typedef struct packed {
		logic [hfdp_pkg::ByteW-1:0]        b;
		logic                              typed;
		logic signed [hfdp_pkg::CodeW-1:0] first;
		logic signed [hfdp_pkg::CodeW-1:0] second;
	} stim_row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [hfdp_pkg::ByteW-1:0]        rx_byte;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [hfdp_pkg::CodeW-1:0] lead_code;
	logic signed [hfdp_pkg::CodeW-1:0] trail_code;

	// local copy of the parser state
	frame_stage_t               frame_stage;
	int                         frame_count;
	logic [hfdp_pkg::ByteW-1:0] frame_buf [PayloadBytes];

	code_pair_t pending_pairs [$];
	int         mismatch_count;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         bytes_sent;

	// header faults, dropped restart, extreme codes and payload abort
	stim_row_t directed_rows [25] = '{
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{"X",             1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB1, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB1, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB2, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB3, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB1, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB2, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB3, 1'b0, 16'sd0, 16'sd0},
		'{8'h00,           1'b0, 16'sd0, 16'sd0},
		'{8'h00,           1'b0, 16'sd0, 16'sd0},
		'{8'h00,           1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{8'hFF,           1'b0, 16'sd0, 16'sd0},
		'{8'hFF,           1'b0, 16'sd0, 16'sd0},
		'{8'hFF,           1'b1, -16'sd5328, 16'sd22977},
		'{hfdp_pkg::HdrB0, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB1, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB2, 1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::HdrB3, 1'b0, 16'sd0, 16'sd0},
		'{"9",             1'b0, 16'sd0, 16'sd0},
		'{hfdp_pkg::AbortByte, 1'b0, 16'sd0, 16'sd0}
	};

	header_framed_decimal_pair_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lead_code  (lead_code),
		.trail_code (trail_code)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// d0*100 + d1*10 + d2 with each digit taken as byte minus ascii zero
	function automatic logic signed [hfdp_pkg::CodeW-1:0] digit_triplet(
		input logic [hfdp_pkg::ByteW-1:0] a,
		input logic [hfdp_pkg::ByteW-1:0] b,
		input logic [hfdp_pkg::ByteW-1:0] c
	);
		int v;
		v = (int'(a) - AsciiZero) * 100 + (int'(b) - AsciiZero) * 10 + (int'(c) - AsciiZero);
		return v[hfdp_pkg::CodeW-1:0];
	endfunction

	// advance the parser model by one byte, returns 1 when a pair is produced
	function automatic bit parse_rx_byte(input logic [hfdp_pkg::ByteW-1:0] b,
			output code_pair_t pair);
		pair = '0;
		if (b == hfdp_pkg::HdrB0 && frame_stage == StageIdle) begin
			frame_stage = StageGotH;
		end else if (b == hfdp_pkg::HdrB1 && frame_stage == StageGotH) begin
			frame_stage = StageGotE;
		end else if (b == hfdp_pkg::HdrB2 && frame_stage == StageGotE) begin
			frame_stage = StageGotA;
		end else if (b == hfdp_pkg::HdrB3 && frame_stage == StageGotA) begin
			frame_stage = StagePayload;
			frame_count = 0;
		end else if (frame_stage == StagePayload && b != hfdp_pkg::AbortByte) begin
			frame_buf[frame_count] = b;
			frame_count++;
			if (frame_count == PayloadBytes) begin
				pair.first  = digit_triplet(frame_buf[0], frame_buf[1], frame_buf[2]);
				pair.second = digit_triplet(frame_buf[4], frame_buf[5], frame_buf[6]);
				frame_stage = StageIdle;
				return 1'b1;
			end
		end else begin
			frame_stage = StageIdle;
		end
		return 1'b0;
	endfunction

	// present one request, wait for it to be taken, then predict
	task automatic send_byte(input logic [hfdp_pkg::ByteW-1:0] b, input logic typed,
			input code_pair_t typed_pair);
		code_pair_t pair;
		bit         has_pair;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		has_pair = parse_rx_byte(b, pair);
		if (typed)
			pending_pairs.push_back(typed_pair);
		else if (has_pair)
			pending_pairs.push_back(pair);
		bytes_sent++;
	endtask

	task automatic send_plain(input logic [hfdp_pkg::ByteW-1:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	// payload byte: mostly ascii digits, sometimes any byte but the abort byte
	function automatic logic [hfdp_pkg::ByteW-1:0] pick_payload_byte();
		logic [hfdp_pkg::ByteW-1:0] b;
		if ($urandom_range(3) != 0)
			return hfdp_pkg::ByteW'("0" + $urandom_range(9));
		do b = hfdp_pkg::ByteW'($urandom_range(255)); while (b == hfdp_pkg::AbortByte);
		return b;
	endfunction

	// one random frame, broken header or run of noise
	task automatic send_random_burst();
		int                         kind;
		int                         cut;
		int                         n;
		logic [hfdp_pkg::ByteW-1:0] b;
		kind = $urandom_range(99);
		if (kind < 70) begin
			for (int i = 0; i < 4; i++)
				send_plain(HeaderSeq[i]);
			cut = ($urandom_range(19) == 0) ? $urandom_range(PayloadBytes - 1) : PayloadBytes;
			for (int i = 0; i < PayloadBytes && i <= cut; i++) begin
				if (i == cut)
					b = hfdp_pkg::AbortByte;
				else if (i == SepIdx && $urandom_range(3) != 0)
					b = ",";
				else
					b = pick_payload_byte();
				send_plain(b);
			end
		end else if (kind < 85) begin
			n = $urandom_range(3);
			for (int i = 0; i < n; i++)
				send_plain(HeaderSeq[i]);
			send_plain(hfdp_pkg::ByteW'($urandom_range(255)));
		end else begin
			n = $urandom_range(6, 1);
			for (int i = 0; i < n; i++)
				send_plain(hfdp_pkg::ByteW'($urandom_range(255)));
		end
	endtask

	// hold the input idle until every predicted pair has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// compare each pair taken with the oldest prediction
	always @(posedge clk) begin
		code_pair_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_pairs.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected pair, expected none, got %0d %0d",
					$time, lead_code, trail_code);
			end else begin
				want = pending_pairs.pop_front();
				if (lead_code !== want.first) begin
					mismatch_count++;
					$display("%0t: lead_code expected %0d, got %0d",
						$time, want.first, lead_code);
				end
				if (trail_code !== want.second) begin
					mismatch_count++;
					$display("%0t: trail_code expected %0d, got %0d",
						$time, want.second, trail_code);
				end
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	// reset, directed table, then three phases of random traffic
	initial begin
		in_valid       = 1'b0;
		rx_byte        = '0;
		out_stall      = 1'b0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		bytes_sent     = 0;
		frame_stage    = StageIdle;
		frame_count    = 0;
		send_idle_pct  = 9;
		recv_stall_pct = 86;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].typed,
				{directed_rows[i].first, directed_rows[i].second});

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 9;
					recv_stall_pct = 86;
				end
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct = 9;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PhaseBytes)
				send_random_burst();
			drain_results();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
src/hfdp_pkg.sv
src/hfdp_in_stage.sv
src/hfdp_parser.sv
src/header_framed_decimal_pair_parser_top.sv
tb/tb_header_framed_decimal_pair_parser_top.sv
